// File: sv/tea_pkg.sv
`timescale 1ns / 1ps

package tea_pkg;

   // Block and word geometry
   localparam int unsigned WORD_W  = 32;
   localparam int unsigned BLOCK_W = 2 * WORD_W;

   // Default cipher configuration
   localparam int unsigned      TEA_ROUNDS = 32;
   localparam logic [WORD_W-1:0] DEFAULT_DELTA = 32'h9E37_79B9;

   // Mixing function shift amounts
   localparam int unsigned SHIFT_LEFT  = 4;
   localparam int unsigned SHIFT_RIGHT = 5;

   // Key register reset values
   localparam logic [WORD_W-1:0] KEY0_RESET = 32'hA56B_ABCD;
   localparam logic [WORD_W-1:0] KEY1_RESET = 32'h0000_FFFF;
   localparam logic [WORD_W-1:0] KEY2_RESET = 32'h1234_5678;
   localparam logic [WORD_W-1:0] KEY3_RESET = 32'h8765_4321;

   // CSR address width: four 32-bit registers at byte addresses 0, 4, 8, 12
   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;

   // Item commands
   localparam logic CMD_ENCRYPT = 1'b0;
   localparam logic CMD_DECRYPT = 1'b1;

   typedef struct packed {
      logic [WORD_W-1:0] key_word_zero;
      logic [WORD_W-1:0] key_word_one;
      logic [WORD_W-1:0] key_word_two;
      logic [WORD_W-1:0] key_word_three;
   } tea_key_type;

   // Data handed from one cell to the next
   typedef struct packed {
      logic              valid;
      logic              cmd;
      logic [WORD_W-1:0] hi;
      logic [WORD_W-1:0] lo;
   } tea_stage_type;

endpackage

// File: sv/tea_if.sv
`timescale 1ns / 1ps

// Input channel: command plus 64-bit block
interface tea_req_if;
   logic                       valid;
   logic                       ready;
   logic                       command;
   logic [tea_pkg::BLOCK_W-1:0] block_in;

   modport source (output valid, output command, output block_in, input ready);
   modport sink   (input valid, input command, input block_in, output ready);
endinterface

// Result channel: processed 64-bit block
interface tea_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [tea_pkg::BLOCK_W-1:0] block_out;

   modport source (output valid, output block_out, input ready);
   modport sink   (input valid, input block_out, output ready);
endinterface

// File: sv/tea_csr.sv
`timescale 1ns / 1ps

module tea_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [tea_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [tea_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [tea_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                          csr_pready,
   output tea_pkg::tea_key_type          key
);
   import tea_pkg::*;

   typedef enum logic [1:0] {
      REG_KEY0 = 2'd0,
      REG_KEY1 = 2'd1,
      REG_KEY2 = 2'd2,
      REG_KEY3 = 2'd3
   } csr_index_type;

   tea_key_type   key_ff;
   tea_key_type   key_in;
   csr_index_type reg_sel;
   logic          wr_en;

   // Word index from the byte address
   assign reg_sel    = csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   // Write decode
   always_comb begin
      key_in = key_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_KEY0: key_in.key_word_zero  = csr_pwdata;
            REG_KEY1: key_in.key_word_one   = csr_pwdata;
            REG_KEY2: key_in.key_word_two   = csr_pwdata;
            REG_KEY3: key_in.key_word_three = csr_pwdata;
            default:  key_in = key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff.key_word_zero  <= KEY0_RESET;
         key_ff.key_word_one   <= KEY1_RESET;
         key_ff.key_word_two   <= KEY2_RESET;
         key_ff.key_word_three <= KEY3_RESET;
      end else begin
         key_ff <= key_in;
      end
   end

   // Read mux
   always_comb begin
      unique case (reg_sel)
         REG_KEY0: csr_prdata = key_ff.key_word_zero;
         REG_KEY1: csr_prdata = key_ff.key_word_one;
         REG_KEY2: csr_prdata = key_ff.key_word_two;
         REG_KEY3: csr_prdata = key_ff.key_word_three;
         default:  csr_prdata = '0;
      endcase
   end

   assign key = key_ff;

endmodule

// File: sv/tea_cell.sv
`timescale 1ns / 1ps

// One half-round of the Feistel network. Even cells update one half, odd
// cells the other; which half depends on the item's direction.
module tea_cell #(
   parameter int unsigned ROUNDS      = tea_pkg::TEA_ROUNDS,
   parameter logic [31:0] ROUND_DELTA = tea_pkg::DEFAULT_DELTA,
   parameter int unsigned CELL_IDX    = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  tea_pkg::tea_key_type   key,
   input  tea_pkg::tea_stage_type stage_in,
   output tea_pkg::tea_stage_type stage_out
);
   import tea_pkg::*;

   localparam int unsigned ROUND_IDX   = CELL_IDX / 2;
   localparam logic        SECOND_HALF = 1'(CELL_IDX % 2);
   // Round sums: delta*(r+1) going forward, delta*(ROUNDS-r) going back
   localparam logic [WORD_W-1:0] ENC_SUM =
      WORD_W'(64'(ROUND_DELTA) * 64'(ROUND_IDX + 1));
   localparam logic [WORD_W-1:0] DEC_SUM =
      WORD_W'(64'(ROUND_DELTA) * 64'(ROUNDS - ROUND_IDX));

   logic              valid_ff;
   logic              cmd_ff;
   logic [WORD_W-1:0] hi_ff;
   logic [WORD_W-1:0] lo_ff;

   logic              update_hi;
   logic [WORD_W-1:0] src_word;
   logic [WORD_W-1:0] dst_word;
   logic [WORD_W-1:0] key_a;
   logic [WORD_W-1:0] key_b;
   logic [WORD_W-1:0] round_sum;
   logic [WORD_W-1:0] mix_word;
   logic [WORD_W-1:0] new_word;
   logic [WORD_W-1:0] hi_in;
   logic [WORD_W-1:0] lo_in;

   // Half selection: encrypt does hi then lo, decrypt lo then hi
   always_comb begin
      update_hi = (stage_in.cmd == SECOND_HALF);
      src_word  = update_hi ? stage_in.lo : stage_in.hi;
      dst_word  = update_hi ? stage_in.hi : stage_in.lo;
      key_a     = update_hi ? key.key_word_zero : key.key_word_two;
      key_b     = update_hi ? key.key_word_one  : key.key_word_three;
      round_sum = (stage_in.cmd == CMD_DECRYPT) ? DEC_SUM : ENC_SUM;
   end

   // Keyed mix and add/subtract into the target half
   always_comb begin
      mix_word = ((src_word << SHIFT_LEFT) + key_a)
               ^ (src_word + round_sum)
               ^ ((src_word >> SHIFT_RIGHT) + key_b);
      new_word = (stage_in.cmd == CMD_DECRYPT) ? (dst_word - mix_word)
                                               : (dst_word + mix_word);
      hi_in    = update_hi ? new_word : stage_in.hi;
      lo_in    = update_hi ? stage_in.lo : new_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         cmd_ff <= stage_in.cmd;
         hi_ff  <= hi_in;
         lo_ff  <= lo_in;
      end
   end

   assign stage_out.valid = valid_ff;
   assign stage_out.cmd   = cmd_ff;
   assign stage_out.hi    = hi_ff;
   assign stage_out.lo    = lo_ff;

endmodule

// File: sv/tea_block_cipher_top.sv
`timescale 1ns / 1ps

// Channel   Direction  Signals                                  Handshake
// req_ch    in         command, block_in[63:0]                  valid/ready
// rsp_ch    out        block_out[63:0]                          valid/ready
// csr_*     in/out     psel, penable, pwrite, paddr[3:0], ...   APB, pready=1
//
// A chain of 2*ROUNDS half-round cells plus an output register, taking one
// item per cycle while the chain is not stalled.
// Synchronous active-high reset clears all valid bits and loads the key
// reset values. The chain stalls as a whole only when the last cell holds an
// item and the output register is full and not being taken.
module tea_block_cipher_top #(
   parameter int unsigned ROUNDS      = tea_pkg::TEA_ROUNDS,
   parameter logic [31:0] ROUND_DELTA = tea_pkg::DEFAULT_DELTA
) (
   input  logic                          clock,
   input  logic                          reset,
   tea_req_if.sink                       req_ch,
   tea_rsp_if.source                     rsp_ch,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [tea_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [tea_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [tea_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                          csr_pready
);
   import tea_pkg::*;

   localparam int unsigned NUM_CELLS = 2 * ROUNDS;

   tea_key_type        key;
   tea_stage_type      stage [NUM_CELLS+1];
   logic               chain_en;
   logic               out_valid_ff;
   logic               out_valid_in;
   logic [BLOCK_W-1:0] out_block_ff;

   // Key registers
   tea_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .key         (key)
   );

   // Chain advances unless the last cell is blocked by a held result
   assign chain_en     = !stage[NUM_CELLS].valid || !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = chain_en;

   // Chain entry
   assign stage[0].valid = req_ch.valid;
   assign stage[0].cmd   = req_ch.command;
   assign stage[0].hi    = req_ch.block_in[BLOCK_W-1:WORD_W];
   assign stage[0].lo    = req_ch.block_in[WORD_W-1:0];

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      tea_cell #(
         .ROUNDS      (ROUNDS),
         .ROUND_DELTA (ROUND_DELTA),
         .CELL_IDX    (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (chain_en),
         .key       (key),
         .stage_in  (stage[i]),
         .stage_out (stage[i+1])
      );
   end

   // Output register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (chain_en && stage[NUM_CELLS].valid) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (chain_en && stage[NUM_CELLS].valid) begin
         out_block_ff <= {stage[NUM_CELLS].hi, stage[NUM_CELLS].lo};
      end
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.block_out = out_block_ff;

endmodule
